// File: src/jet_pkg.sv
// Package for the Julia escape-time test block.
// Holds the fixed-point types, constants and the saturation helper; no dependencies.
package jet_pkg;

    localparam int FRAC_BITS = 28;
    localparam int ACC_W     = 40;
    localparam int SQ_W      = 60;

    typedef logic signed [31:0]      coord_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [SQ_W-1:0]         sq_t;

    typedef struct packed {
        logic valid;
        logic trapped;
    } tag_t;

    localparam acc_t SAT_MAX     = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t SAT_MIN     = {1'b1, {(ACC_W-1){1'b0}}};
    localparam acc_t TWO_FIX     = acc_t'(40'sd536870912);
    localparam acc_t NEG_TWO_FIX = acc_t'(-40'sd536870912);
    localparam logic [SQ_W:0] FOUR_Q56 = (SQ_W+1)'(1) << 58;

    function automatic acc_t sat40(input logic signed [ACC_W:0] v);
        acc_t r;
        if (v[ACC_W] != v[ACC_W-1]) begin
            r = v[ACC_W] ? SAT_MIN : SAT_MAX;
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/julia_escape_test_top.sv
// Top level of the Julia escape-time test: four-stage iteration ring and output register.
// Depends on jet_pkg, jet_step and jet_escape.
//
// Each point circulates through a four-stage loop (products, add and saturate, squares,
// escape compare) once per Z*Z + C step, so a point runs L steps with L the smaller of
// iteration_limit and MAX_ITERATIONS, or one silent pass when that is zero. A point
// always runs all L passes, which keeps results in input order. Up to four points share
// the loop, and a new point is accepted only when the slot at the loop's end is not
// recirculating. With a zero limit each point makes one pass, and the loop takes one
// point per cycle at most while no result beat stalls. A stalled result beat holds the
// whole loop.
module julia_escape_test_top #(
    parameter int MAX_ITERATIONS = 255
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,     // iteration_limit
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,         // z_re, z_im, c_re, c_im
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata          // is_trapped, then zero padding
);

    localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);

    logic [7:0]        limit_reg;
    logic [CNT_W-1:0]  lim_eff;
    logic [CNT_W-1:0]  loop_len;
    logic              active;

    jet_pkg::tag_t     s1_tag_reg;
    jet_pkg::tag_t     s1_tag_next;
    jet_pkg::coord_t   s1_re_reg;
    jet_pkg::coord_t   s1_re_next;
    jet_pkg::coord_t   s1_im_reg;
    jet_pkg::coord_t   s1_im_next;
    jet_pkg::coord_t   s1_cr_reg;
    jet_pkg::coord_t   s1_cr_next;
    jet_pkg::coord_t   s1_ci_reg;
    jet_pkg::coord_t   s1_ci_next;
    logic [CNT_W-1:0]  s1_cnt_reg;
    logic [CNT_W-1:0]  s1_cnt_next;

    jet_pkg::tag_t     s3_tag;
    jet_pkg::acc_t     s3_nr;
    jet_pkg::acc_t     s3_ni;
    jet_pkg::coord_t   s3_cr;
    jet_pkg::coord_t   s3_ci;
    logic [CNT_W-1:0]  s3_cnt;

    jet_pkg::tag_t     s4_tag;
    logic              s4_big;
    jet_pkg::sq_t      s4_rr;
    jet_pkg::sq_t      s4_ii;
    jet_pkg::coord_t   s4_re;
    jet_pkg::coord_t   s4_im;
    jet_pkg::coord_t   s4_cr;
    jet_pkg::coord_t   s4_ci;
    logic [CNT_W-1:0]  s4_cnt;

    logic [jet_pkg::SQ_W:0] sq_sum;
    logic              esc;
    logic              kill;
    logic              trapped_new;
    logic [CNT_W-1:0]  cnt_inc;
    logic              done;
    logic              exit_beat;
    logic              recirc;
    logic              out_ready;
    logic              en;

    logic              m_valid_reg;
    logic              m_trapped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 8'd64;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (32'(limit_reg) > 32'(MAX_ITERATIONS)) begin
            lim_eff = CNT_W'(MAX_ITERATIONS);
        end else begin
            lim_eff = CNT_W'(limit_reg);
        end
        active   = (lim_eff != '0);
        loop_len = active ? lim_eff : CNT_W'(1);
    end

    always_comb begin
        sq_sum      = {1'b0, s4_rr} + {1'b0, s4_ii};
        esc         = s4_big || (sq_sum > jet_pkg::FOUR_Q56);
        trapped_new = s4_tag.trapped & ~(active & esc);
        kill        = esc | ~s4_tag.trapped | ~active;
        cnt_inc     = s4_cnt + CNT_W'(1);
        done        = (cnt_inc == loop_len);
        exit_beat   = s4_tag.valid & done;
        recirc      = s4_tag.valid & ~done;
        out_ready   = ~m_valid_reg | m_tready;
        en          = ~(exit_beat & ~out_ready);
        s_tready    = en & ~recirc;
    end

    always_comb begin
        s1_tag_next = s1_tag_reg;
        s1_re_next  = s1_re_reg;
        s1_im_next  = s1_im_reg;
        s1_cr_next  = s1_cr_reg;
        s1_ci_next  = s1_ci_reg;
        s1_cnt_next = s1_cnt_reg;
        if (en) begin
            if (recirc) begin
                s1_tag_next.valid   = 1'b1;
                s1_tag_next.trapped = trapped_new;
                s1_re_next          = kill ? '0 : s4_re;
                s1_im_next          = kill ? '0 : s4_im;
                s1_cr_next          = s4_cr;
                s1_ci_next          = s4_ci;
                s1_cnt_next         = cnt_inc;
            end else begin
                s1_tag_next.valid   = s_tvalid;
                s1_tag_next.trapped = 1'b1;
                s1_re_next          = s_tdata[31:0];
                s1_im_next          = s_tdata[63:32];
                s1_cr_next          = s_tdata[95:64];
                s1_ci_next          = s_tdata[127:96];
                s1_cnt_next         = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg <= '0;
        end else begin
            s1_tag_reg <= s1_tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_re_reg  <= s1_re_next;
        s1_im_reg  <= s1_im_next;
        s1_cr_reg  <= s1_cr_next;
        s1_ci_reg  <= s1_ci_next;
        s1_cnt_reg <= s1_cnt_next;
    end

    jet_step #(
        .CNT_W (CNT_W)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_tag  (s1_tag_reg),
        .in_re   (s1_re_reg),
        .in_im   (s1_im_reg),
        .in_cr   (s1_cr_reg),
        .in_ci   (s1_ci_reg),
        .in_cnt  (s1_cnt_reg),
        .out_tag (s3_tag),
        .out_nr  (s3_nr),
        .out_ni  (s3_ni),
        .out_cr  (s3_cr),
        .out_ci  (s3_ci),
        .out_cnt (s3_cnt)
    );

    jet_escape #(
        .CNT_W (CNT_W)
    ) u_escape (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_tag  (s3_tag),
        .in_nr   (s3_nr),
        .in_ni   (s3_ni),
        .in_cr   (s3_cr),
        .in_ci   (s3_ci),
        .in_cnt  (s3_cnt),
        .out_tag (s4_tag),
        .out_big (s4_big),
        .out_rr  (s4_rr),
        .out_ii  (s4_ii),
        .out_re  (s4_re),
        .out_im  (s4_im),
        .out_cr  (s4_cr),
        .out_ci  (s4_ci),
        .out_cnt (s4_cnt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exit_beat && en) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exit_beat && en) begin
            m_trapped_reg <= trapped_new;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_trapped_reg};

endmodule

// File: src/jet_step.sv
// One Z*Z + C step over two register stages: products, then shift, add and saturate.
// Depends on jet_pkg.
module jet_step #(
    parameter int CNT_W = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  jet_pkg::tag_t        in_tag,
    input  jet_pkg::coord_t      in_re,
    input  jet_pkg::coord_t      in_im,
    input  jet_pkg::coord_t      in_cr,
    input  jet_pkg::coord_t      in_ci,
    input  logic [CNT_W-1:0]     in_cnt,
    output jet_pkg::tag_t        out_tag,
    output jet_pkg::acc_t        out_nr,
    output jet_pkg::acc_t        out_ni,
    output jet_pkg::coord_t      out_cr,
    output jet_pkg::coord_t      out_ci,
    output logic [CNT_W-1:0]     out_cnt
);

    jet_pkg::tag_t       s2_tag_reg;
    logic signed [63:0]  s2_rr_reg;
    logic signed [63:0]  s2_ii_reg;
    logic signed [63:0]  s2_ri_reg;
    jet_pkg::coord_t     s2_cr_reg;
    jet_pkg::coord_t     s2_ci_reg;
    logic [CNT_W-1:0]    s2_cnt_reg;

    jet_pkg::tag_t       s3_tag_reg;
    jet_pkg::acc_t       s3_nr_reg;
    jet_pkg::acc_t       s3_ni_reg;
    jet_pkg::coord_t     s3_cr_reg;
    jet_pkg::coord_t     s3_ci_reg;
    logic [CNT_W-1:0]    s3_cnt_reg;

    logic signed [64:0]  diff;
    logic signed [40:0]  nr_sum;
    logic signed [40:0]  ni_sum;
    jet_pkg::acc_t       nr_next;
    jet_pkg::acc_t       ni_next;

    always_comb begin
        diff    = 65'(s2_rr_reg) - 65'(s2_ii_reg);
        nr_sum  = 41'($signed(diff[64:jet_pkg::FRAC_BITS])) + 41'(s2_cr_reg);
        ni_sum  = 41'($signed(s2_ri_reg[63:jet_pkg::FRAC_BITS-1])) + 41'(s2_ci_reg);
        nr_next = jet_pkg::sat40(nr_sum);
        ni_next = jet_pkg::sat40(ni_sum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end else if (en) begin
            s2_tag_reg <= in_tag;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_rr_reg  <= 64'(in_re) * 64'(in_re);
            s2_ii_reg  <= 64'(in_im) * 64'(in_im);
            s2_ri_reg  <= 64'(in_re) * 64'(in_im);
            s2_cr_reg  <= in_cr;
            s2_ci_reg  <= in_ci;
            s2_cnt_reg <= in_cnt;
            s3_nr_reg  <= nr_next;
            s3_ni_reg  <= ni_next;
            s3_cr_reg  <= s2_cr_reg;
            s3_ci_reg  <= s2_ci_reg;
            s3_cnt_reg <= s2_cnt_reg;
        end
    end

    assign out_tag = s3_tag_reg;
    assign out_nr  = s3_nr_reg;
    assign out_ni  = s3_ni_reg;
    assign out_cr  = s3_cr_reg;
    assign out_ci  = s3_ci_reg;
    assign out_cnt = s3_cnt_reg;

endmodule

// File: src/jet_escape.sv
// Escape-test stage: range check and squares of the new Z, registered.
// Depends on jet_pkg.
module jet_escape #(
    parameter int CNT_W = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  jet_pkg::tag_t        in_tag,
    input  jet_pkg::acc_t        in_nr,
    input  jet_pkg::acc_t        in_ni,
    input  jet_pkg::coord_t      in_cr,
    input  jet_pkg::coord_t      in_ci,
    input  logic [CNT_W-1:0]     in_cnt,
    output jet_pkg::tag_t        out_tag,
    output logic                 out_big,
    output jet_pkg::sq_t         out_rr,
    output jet_pkg::sq_t         out_ii,
    output jet_pkg::coord_t      out_re,
    output jet_pkg::coord_t      out_im,
    output jet_pkg::coord_t      out_cr,
    output jet_pkg::coord_t      out_ci,
    output logic [CNT_W-1:0]     out_cnt
);

    jet_pkg::tag_t       tag_reg;
    logic                big_reg;
    jet_pkg::sq_t        rr_reg;
    jet_pkg::sq_t        ii_reg;
    jet_pkg::coord_t     re_reg;
    jet_pkg::coord_t     im_reg;
    jet_pkg::coord_t     cr_reg;
    jet_pkg::coord_t     ci_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                big_next;
    logic signed [30:0]  re_lo;
    logic signed [30:0]  im_lo;
    logic signed [61:0]  rr_full;
    logic signed [61:0]  ii_full;

    always_comb begin
        big_next = (in_nr > jet_pkg::TWO_FIX) || (in_nr < jet_pkg::NEG_TWO_FIX) ||
                   (in_ni > jet_pkg::TWO_FIX) || (in_ni < jet_pkg::NEG_TWO_FIX);
        re_lo    = in_nr[30:0];
        im_lo    = in_ni[30:0];
        rr_full  = 62'(re_lo) * 62'(re_lo);
        ii_full  = 62'(im_lo) * 62'(im_lo);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (en) begin
            tag_reg <= in_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            big_reg <= big_next;
            rr_reg  <= rr_full[jet_pkg::SQ_W-1:0];
            ii_reg  <= ii_full[jet_pkg::SQ_W-1:0];
            re_reg  <= in_nr[31:0];
            im_reg  <= in_ni[31:0];
            cr_reg  <= in_cr;
            ci_reg  <= in_ci;
            cnt_reg <= in_cnt;
        end
    end

    assign out_tag = tag_reg;
    assign out_big = big_reg;
    assign out_rr  = rr_reg;
    assign out_ii  = ii_reg;
    assign out_re  = re_reg;
    assign out_im  = im_reg;
    assign out_cr  = cr_reg;
    assign out_ci  = ci_reg;
    assign out_cnt = cnt_reg;

endmodule

// File: sim/julia_escape_test_top_tb.sv
// Self-checking testbench for julia_escape_test_top: drives 4D points on the input stream
// and compares each is_trapped beat with an escape-time predictor held in a scoreboard class.
// Depends on jet_pkg and julia_escape_test_top.
module julia_escape_test_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITERS   = 255;
    localparam int WATCH_LIMIT = 20000;
    localparam int ONE         = 1 << jet_pkg::FRAC_BITS;
    localparam int TWO         = 2 * ONE;
    localparam int HALF        = ONE / 2;
    localparam int QUARTER     = ONE / 4;

    class escape_scoreboard;
        bit [7:0]    trapped_q[$];
        int unsigned limit;
        int          max_steps;
        int          faults;

        function new(int steps);
            max_steps = steps;
            limit     = 64;
            faults    = 0;
        endfunction

        function longint clamp40(longint v);
            longint hi;
            longint lo;
            hi = longint'(jet_pkg::SAT_MAX);
            lo = longint'(jet_pkg::SAT_MIN);
            if (v > hi) begin
                return hi;
            end else if (v < lo) begin
                return lo;
            end
            return v;
        endfunction

        function bit outside_radius(longint re, longint im);
            longint two;
            longint mre;
            longint mim;
            two = longint'(jet_pkg::TWO_FIX);
            mre = (re < 0) ? -re : re;
            mim = (im < 0) ? -im : im;
            if (mre > two || mim > two) begin
                return 1'b1;
            end
            return (re * re + im * im) > (64'sd1 <<< 58);
        endfunction

        function bit trapped_after(logic [127:0] d);
            longint re;
            longint im;
            longint cre;
            longint cim;
            longint nre;
            longint nim;
            int     steps;
            re    = jet_pkg::coord_t'(d[31:0]);
            im    = jet_pkg::coord_t'(d[63:32]);
            cre   = jet_pkg::coord_t'(d[95:64]);
            cim   = jet_pkg::coord_t'(d[127:96]);
            steps = (limit > max_steps) ? max_steps : int'(limit);
            for (int k = 0; k < steps; k++) begin
                nre = clamp40(((re * re - im * im) >>> jet_pkg::FRAC_BITS) + cre);
                nim = clamp40(((re * im) >>> (jet_pkg::FRAC_BITS - 1)) + cim);
                re  = nre;
                im  = nim;
                if (outside_radius(re, im)) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_point(logic [127:0] d);
            trapped_q.push_back({7'd0, trapped_after(d)});
        endfunction

        function void check_result(logic [7:0] got);
            bit [7:0] want;
            if (trapped_q.size() == 0) begin
                faults++;
                if (faults <= 10) begin
                    $display("Unexpected result beat: m_tdata=%h", got);
                end
                return;
            end
            want = trapped_q.pop_front();
            if (got !== want) begin
                faults++;
                if (faults <= 10) begin
                    $display("is_trapped mismatch: expected %h, actual %h", want, got);
                end
            end
        endfunction

        function int pending();
            return trapped_q.size();
        endfunction
    endclass

    logic         aclk;
    logic         aresetn     = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic [7:0]   cfg_wr_data = 8'd0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata     = '0;
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [7:0]   m_tdata;

    bit               calm = 1'b0;
    int               stall_left = 0;
    int               quiet_cycles = 0;
    escape_scoreboard sb = new(MAX_ITERS);

    julia_escape_test_top #(
        .MAX_ITERATIONS(MAX_ITERS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            quiet_cycles++;
            if (s_tvalid && s_tready) begin
                sb.note_point(s_tdata);
                quiet_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= WATCH_LIMIT) begin
                $display("julia_escape_test_top_tb: FAIL");
                $finish;
            end
        end
    end

    function automatic logic [127:0] pack_point(int zr, int zi, int cr, int ci);
        return {ci, cr, zi, zr};
    endfunction

    function automatic int rand_fix(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic [127:0] directed_point(int k);
        case (k)
            0:       return pack_point(0, 0, 0, 0);
            1:       return {4{32'h7FFF_FFFF}};
            2:       return {4{32'h8000_0000}};
            3:       return pack_point(HALF, 0, 0, 0);
            4:       return pack_point(0, 0, TWO, 0);
            5:       return pack_point(0, 0, -TWO, 0);
            6:       return pack_point(0, 0, 0, ONE);
            7:       return pack_point(0, 0, QUARTER, 0);
            8:       return pack_point(0, 0, QUARTER + ONE / 100, 0);
            9:       return pack_point(-ONE, 0, -ONE, 0);
            10:      return pack_point(TWO, TWO, 0, 0);
            default: return {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
        endcase
    endfunction

    function automatic logic [127:0] random_point();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            return {$urandom, $urandom, $urandom, $urandom};
        end else if (pick < 60) begin
            return pack_point(rand_fix(-HALF, HALF), rand_fix(-HALF, HALF),
                              rand_fix(-(3 * ONE) / 2, HALF), rand_fix(-ONE, ONE));
        end
        return pack_point(rand_fix(-TWO, TWO), rand_fix(-TWO, TWO),
                          rand_fix(-TWO, TWO), rand_fix(-TWO, TWO));
    endfunction

    task automatic send_point(input logic [127:0] d);
        int unsigned gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_limit(input int unsigned v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[7:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.limit = v;
    endtask

    initial begin
        int          at_zero[4]  = '{1, 2, 4, 10};
        int          at_one[4]   = '{4, 10, 0, 2};
        int          at_full[4]  = '{7, 8, 6, 5};
        int unsigned lim;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 12; i++) begin
            send_point(directed_point(i));
        end
        drain();
        set_limit(0);
        foreach (at_zero[i]) send_point(directed_point(at_zero[i]));
        drain();
        set_limit(1);
        foreach (at_one[i]) send_point(directed_point(at_one[i]));
        drain();
        set_limit(255);
        foreach (at_full[i]) send_point(directed_point(at_full[i]));

        for (int p = 0; p < 10; p++) begin
            case (p)
                0:       lim = 255;
                1:       lim = 0;
                2:       lim = 1;
                3:       lim = 2;
                9:       lim = 64;
                default: lim = (p % 2 != 0) ? $urandom_range(0, 255) : $urandom_range(3, 40);
            endcase
            drain();
            if (p == 9) begin
                calm = 1'b1;
            end
            set_limit(lim);
            repeat (125) send_point(random_point());
        end

        drain();
        repeat (4 * MAX_ITERS + 16) @(posedge aclk);
        if (sb.faults == 0 && sb.pending() == 0) begin
            $display("julia_escape_test_top_tb: PASS");
        end else begin
            $display("julia_escape_test_top_tb: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/jet_pkg.sv
src/jet_step.sv
src/jet_escape.sv
src/julia_escape_test_top.sv
sim/julia_escape_test_top_tb.sv
